### hdl/caa_pkg.sv
// Shared types and constants for the calibrated altitude averager.
// Used by caa_divider, calibrated_altitude_averager and the testbench; depends on nothing.
`default_nettype none

package caa_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int RANGE_BITS    = 12;
  localparam int ALT_BITS      = 10;
  localparam int ALT_MAX       = 1023;
  localparam int PERCENT_SCALE = 100;

  localparam logic [RANGE_BITS-1:0] RANGE_RESET = 12'd993;

  // Register word index decoded from the configuration address.
  localparam logic REG_RANGE = 1'b0;

  typedef struct packed {
    logic busy;
    logic done;
  } caa_div_stat_t;

endpackage

`default_nettype wire

### hdl/calibrated_altitude_averager.sv
// Transfers are accepted one at a time: the next sample is taken only after the last reading has
// entered the output register. The altitude percent is formed by the bit-per-cycle divider; an
// uncalibrated or zero-span reading skips the divider. The result enters the output register at
// the edge at which ready returns, and a stalled output holds the sequencer. Synchronous active-low
// reset clears the ring position and fill count, sum and levels, and loads the range register with
// RANGE_RESET, all at once. Depends on caa_pkg, caa_ring and caa_divider.
`default_nettype none

module calibrated_altitude_averager #(
  parameter int WINDOW_DEPTH = caa_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = caa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // Fields from bit 0: sample, recalibrate, zero padding.
  input  wire logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] in_tdata,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // Fields from bit 0: altitude_percent, mean_level, zero padding.
  output logic [((caa_pkg::ALT_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // Fields from bit 0: calibrated.
  output logic      out_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import caa_pkg::*;

  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int FW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = SAMPLE_BITS + AW;
  localparam int NW   = SAMPLE_BITS + 10;
  localparam int DW   = SAMPLE_BITS + 3;
  localparam int SPW  = SAMPLE_BITS + 2;
  localparam int NSW  = SAMPLE_BITS + 11;
  localparam int QW   = NW + 2;
  localparam int TW   = SAMPLE_BITS + 1;
  localparam int CW   = (TW > RANGE_BITS) ? TW : RANGE_BITS;
  localparam int OW   = ((ALT_BITS + SAMPLE_BITS + 7) / 8) * 8;
  localparam int TWICE_SCALE = 2 * PERCENT_SCALE;
  localparam int MK   = SUMW + AW;
  localparam int MW   = SUMW + 2;
  localparam int PW   = SUMW + MW;
  localparam longint RECIP_L =
    ((longint'(1) << MK) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);

  localparam logic [FW-1:0]   FILL_FULL = FW'(WINDOW_DEPTH);
  localparam logic [AW-1:0]   POS_LAST  = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW-1:0]   POS_ONE   = AW'(1);
  localparam logic [FW-1:0]   FILL_ONE  = FW'(1);
  localparam logic [SUMW-1:0] MAX_SUM   = SUMW'(WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1));
  localparam logic [MW-1:0]   RECIP     = MW'(RECIP_L);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MEAN = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_ALT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [RANGE_BITS-1:0]  range_r, range_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [SUMW-1:0]        sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] ground_r, ground_nxt;
  logic [TW-1:0]          top_r, top_nxt;
  logic                   cal_r, cal_nxt;
  logic                   just_r, just_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                   recal_r, recal_nxt;
  logic [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic [ALT_BITS-1:0]    alt_r, alt_nxt;
  logic                   neg_r, neg_nxt;
  logic [ALT_BITS-1:0]    out_alt_r, out_alt_nxt;
  logic [SAMPLE_BITS-1:0] out_mean_r, out_mean_nxt;
  logic                   out_cal_r, out_cal_nxt;

  logic                   in_fire;
  logic                   cfg_write;
  logic                   rd_en;
  logic                   wr_en;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic                   div_start;
  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic [NW-1:0]          div_quo;
  caa_div_stat_t          div_stat;

  logic [PW-1:0]          mean_prod;
  logic [CW-1:0]          top_diff;
  logic signed [TW-1:0]   top_s;
  logic signed [SPW-1:0]  span_s;
  logic signed [SPW-1:0]  d_s;
  logic signed [NSW-1:0]  n_s;
  logic [NW-1:0]          n_abs;
  logic [SPW-1:0]         span_abs;
  logic signed [QW-1:0]   q_s;

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_RANGE) ? 32'(range_r) : 32'd0;

  assign rd_en      = in_fire;
  assign wr_en      = (state_r == S_READ);
  assign old_sample = (fill_r == FILL_FULL) ? rd_data : '0;

  caa_ring #(
    .DEPTH  (WINDOW_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pos_r),
    .wr_data (sample_r)
  );

  caa_divider #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  always_comb begin
    // Exact reciprocal multiplication stands in for the division by the window depth.
    mean_prod = {{MW{1'b0}}, sum_r} * {{SUMW{1'b0}}, RECIP};
    top_s    = $signed(top_r);
    span_s   = SPW'($signed({1'b0, ground_r})) - SPW'(top_s);
    d_s      = SPW'($signed({1'b0, mean_r})) - SPW'(top_s);
    n_s      = NSW'(d_s) * NSW'(TWICE_SCALE) + NSW'(span_s);
    n_abs    = n_s[NSW-1] ? NW'(-n_s) : NW'(n_s);
    span_abs = span_s[SPW-1] ? SPW'(-span_s) : SPW'(span_s);
    top_diff = CW'(mean_r) - CW'(range_r);
    q_s      = neg_r ? (QW'(PERCENT_SCALE) - $signed({2'b00, div_quo}))
                     : (QW'(PERCENT_SCALE) + $signed({2'b00, div_quo}));
  end

  always_comb begin
    state_nxt     = state_r;
    range_nxt     = range_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    ground_nxt    = ground_r;
    top_nxt       = top_r;
    cal_nxt       = cal_r;
    just_nxt      = just_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    recal_nxt     = recal_r;
    mean_nxt      = mean_r;
    alt_nxt       = alt_r;
    neg_nxt       = neg_r;
    out_alt_nxt   = out_alt_r;
    out_mean_nxt  = out_mean_r;
    out_cal_nxt   = out_cal_r;
    div_start     = 1'b0;
    div_num       = n_abs;
    div_den       = {span_abs, 1'b0};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_write && (cfg_paddr[2] == REG_RANGE)) begin
      range_nxt = cfg_pwdata[RANGE_BITS-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_nxt = in_tdata[SAMPLE_BITS-1:0];
          recal_nxt  = in_tdata[SAMPLE_BITS];
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        sum_nxt   = sum_r - SUMW'(old_sample) + SUMW'(sample_r);
        pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + POS_ONE;
        just_nxt  = (fill_r == FILL_FULL - FILL_ONE);
        if (fill_r != FILL_FULL) begin
          fill_nxt = fill_r + FILL_ONE;
        end
        state_nxt = S_MEAN;
      end
      S_MEAN: begin
        mean_nxt  = mean_prod[MK +: SAMPLE_BITS];
        state_nxt = S_PREP;
      end
      S_PREP: begin
        if (just_r || (recal_r && (fill_r == FILL_FULL))) begin
          ground_nxt = mean_r;
          top_nxt    = top_diff[TW-1:0];
          cal_nxt    = 1'b1;
          // Levels change; redo this step next time around with the new levels.
          just_nxt   = 1'b0;
          recal_nxt  = 1'b0;
          state_nxt  = S_PREP;
        end else if (!cal_r || (span_s == '0)) begin
          alt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          neg_nxt   = n_s[NSW-1] ^ ~span_s[SPW-1];
          div_start = 1'b1;
          state_nxt = S_ALT;
        end
      end
      S_ALT: begin
        if (div_stat.done) begin
          if (q_s < 0) begin
            alt_nxt = '0;
          end else if (q_s > QW'(ALT_MAX)) begin
            alt_nxt = ALT_BITS'(ALT_MAX);
          end else begin
            alt_nxt = q_s[ALT_BITS-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_alt_nxt   = alt_r;
          out_mean_nxt  = mean_r;
          out_cal_nxt   = cal_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      range_r     <= RANGE_RESET;
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      ground_r    <= '0;
      top_r       <= '0;
      cal_r       <= 1'b0;
      just_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      range_r     <= range_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      ground_r    <= ground_nxt;
      top_r       <= top_nxt;
      cal_r       <= cal_nxt;
      just_r      <= just_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    recal_r    <= recal_nxt;
    mean_r     <= mean_nxt;
    alt_r      <= alt_nxt;
    neg_r      <= neg_nxt;
    out_alt_r  <= out_alt_nxt;
    out_mean_r <= out_mean_nxt;
    out_cal_r  <= out_cal_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_cal_r;
  assign out_tdata  = OW'({out_mean_r, out_alt_r});

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count exceeds window depth");

  a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= MAX_SUM)
    else $error("running sum exceeds the largest possible window total");

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |=> cal_r)
    else $error("calibration flag dropped");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_uncal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !cal_r) |-> (alt_r == '0))
    else $error("altitude nonzero before calibration");

endmodule

`default_nettype wire

### hdl/caa_ring.sv
// Sample ring storage: one write port and one registered read port.
// Standalone memory; no package dependencies.
`default_nettype none

module caa_ring #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/caa_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on caa_pkg for the status struct.
`default_nettype none

module caa_divider #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [NUM_W-1:0]       num,
  input  wire logic [DEN_W-1:0]       den,
  output logic      [NUM_W-1:0]       quo,
  output caa_pkg::caa_div_stat_t      stat
);

  import caa_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(NUM_W);

  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_r, acc_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    fits    = (rem_sh >= {1'b0, den_r});
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_LOAD;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[NUM_W-2:0], fits};
      rem_nxt = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_ONE;
      if (cnt_r == CNT_ONE) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

### test/caa_result_checker.sv
// Result checker for the calibrated altitude averager: watches the sample, result and
// register channels, predicts each reading and compares it with the block's output.
// Depends on caa_pkg.
`timescale 1ns / 1ps

module caa_result_checker
  import caa_pkg::*;
#(
  parameter int IN_W  = 16,
  parameter int OUT_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  input  logic             cfg_pready,
  output int               mismatches,
  output int               pending
);

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam int PBITS = $clog2(DEPTH);

  typedef struct packed {
    logic [ALT_BITS-1:0] altitude;
    logic [SBITS-1:0]    mean;
    logic                calibrated;
  } reading_t;

  reading_t expected_readings[$];

  logic [SBITS-1:0]        sample_ring [DEPTH];
  logic [PBITS-1:0]        wr_pos;
  logic [SBITS+PBITS-1:0]  running_total;
  int                      fill;
  logic [SBITS-1:0]        ground;
  logic signed [SBITS:0]   top;
  logic                    cal;
  logic [RANGE_BITS-1:0]   range_cnt;

  int n_err = 0;
  int n_pending = 0;

  assign mismatches = n_err;
  assign pending    = n_pending;

  function automatic logic [ALT_BITS-1:0] altitude_pct(input logic [SBITS-1:0] mean);
    longint top_s, span, d, num, den, q;
    top_s = longint'(top);
    span  = longint'(ground) - top_s;
    d     = longint'(mean) - top_s;
    if (!cal || span == 0) return '0;
    num = 2 * (d * PERCENT_SCALE) + span;
    den = -2 * span;
    q   = num / den + PERCENT_SCALE;
    if (q < 0) q = 0;
    if (q > ALT_MAX) q = ALT_MAX;
    return q[ALT_BITS-1:0];
  endfunction

  // Stores the sample, updates the sum and fill level, captures the levels when due
  // and returns the reading the block has to produce for this transfer.
  function automatic reading_t filter_step(input logic [SBITS-1:0] s, input logic recal);
    reading_t r;
    logic [SBITS-1:0] mean;
    logic just_full;
    running_total = running_total - sample_ring[wr_pos] + s;
    sample_ring[wr_pos] = s;
    wr_pos = wr_pos + 1'b1;
    just_full = 1'b0;
    if (fill < DEPTH) begin
      fill++;
      just_full = (fill == DEPTH);
    end
    mean = running_total[SBITS+PBITS-1:PBITS];
    if (just_full || (recal && fill == DEPTH)) begin
      ground = mean;
      top    = $signed({1'b0, mean}) - $signed({1'b0, range_cnt});
      cal    = 1'b1;
    end
    r.altitude   = altitude_pct(mean);
    r.mean       = mean;
    r.calibrated = cal;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin : watch
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      foreach (sample_ring[i]) sample_ring[i] = '0;
      wr_pos        = '0;
      running_total = '0;
      fill          = 0;
      ground        = '0;
      top           = '0;
      cal           = 1'b0;
      range_cnt     = RANGE_RESET;
      expected_readings.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == REG_RANGE)
        range_cnt = cfg_pwdata[RANGE_BITS-1:0];
      if (in_tvalid && in_tready)
        expected_readings.push_back(filter_step(in_tdata[SBITS-1:0], in_tdata[SBITS]));
      if (out_tvalid && out_tready) begin
        got.altitude   = out_tdata[ALT_BITS-1:0];
        got.mean       = out_tdata[ALT_BITS +: SBITS];
        got.calibrated = out_tuser;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual altitude %0d mean %0d",
                   $time, got.altitude, got.mean);
          n_err++;
        end else begin
          want = expected_readings.pop_front();
          check_field("altitude_percent", want.altitude, got.altitude);
          check_field("mean_level", want.mean, got.mean);
          check_field("calibrated", want.calibrated, got.calibrated);
        end
      end
    end
    n_pending <= expected_readings.size();
  end

endmodule

### test/tb_calibrated_altitude_averager.sv
// Top of the calibrated altitude averager testbench: clock, reset, sample stimulus,
// range register writes and output back-pressure; the verdict comes from caa_result_checker.
// Depends on caa_pkg, caa_result_checker and the block itself.
`timescale 1ns / 1ps

module tb_calibrated_altitude_averager;
  import caa_pkg::*;

  localparam int SBITS        = SAMPLE_BITS_DEF;
  localparam int IN_W         = ((SBITS + 8) / 8) * 8;
  localparam int OUT_W        = ((ALT_BITS + SBITS + 7) / 8) * 8;
  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic [2:0] RANGE_ADDR = {REG_RANGE, 2'b00};

  logic clk;
  logic rst_n = 1'b0;

  // Fields from bit 0: sample, recalibrate, zero padding.
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // Fields from bit 0: altitude_percent, mean_level, zero padding.
  logic [OUT_W-1:0] out_tdata;
  // Fields from bit 0: calibrated.
  logic             out_tuser;
  logic             out_tvalid;
  logic             out_tready = 1'b0;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int level = 2048;

  calibrated_altitude_averager u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  caa_result_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [SBITS-1:0] s, input logic recal);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tdata  <= IN_W'({recal, s});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !in_tready);
  endtask

  task automatic write_range(input logic [RANGE_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= RANGE_ADDR;
    cfg_pwdata  <= {20'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mostly samples scattered around a level that now and then jumps to a new random
  // value, with full-scale extremes and uniform noise mixed in.
  function automatic logic [SBITS-1:0] next_sample();
    int v;
    if ($urandom_range(39) == 0) level = $urandom_range(4095);
    case ($urandom_range(9))
      0:       v = $urandom_range(1) ? 4095 : 0;
      1, 2:    v = $urandom_range(4095);
      default: v = level + int'($urandom_range(64)) - 32;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SBITS-1:0];
  endfunction

  initial begin : stimulus
    int range_plan[8];
    int rv;
    range_plan = '{4095, 1, 0, -1, 993, 1, 4095, -1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A recalibration request before the ring is full must be ignored; the ring
    // then fills with full-scale samples, which triggers the first capture.
    send_sample(12'hFFF, 1'b1);
    repeat (15) send_sample(12'hFFF, 1'b0);
    send_sample(12'h000, 1'b1);
    repeat (3) send_sample(12'h000, 1'b0);
    send_sample(12'hFFF, 1'b1);
    send_sample(12'h800, 1'b0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      rv = (range_plan[p] < 0) ? $urandom_range(4095) : range_plan[p];
      write_range(rv[RANGE_BITS-1:0]);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(next_sample(), $urandom_range(9) == 0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
